### hw/rtl/cfpd_pkg.sv
// Shared types, constants and saturating helpers for the focal-plane distortion map.
// No dependencies; imported by every module under hw/rtl.
package cfpd_pkg;

  localparam int unsigned COORD_W    = 32;  // Q8.24 coordinates
  localparam int unsigned COEF_W     = 40;  // Q4.36 coefficients
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 40;
  localparam int unsigned VAL_W      = 63;  // holds +-(2^62 - 1)

  // Multiplier pipeline and unit latencies, in cycles.
  localparam int unsigned MUL_LAT   = 5;
  localparam int unsigned PERSP_LAT = 2 * MUL_LAT + 3;
  localparam int unsigned RAD_LAT   = 3 * MUL_LAT + 4;

  // Post-product right shifts.
  localparam int unsigned PERSP_SH = 24;
  localparam int unsigned Q36_SH   = 36;
  localparam int unsigned SQ_SH    = 0;
  localparam int unsigned K1_SH    = 48;

  typedef logic signed [VAL_W-1:0] val_t;

  localparam val_t SAT_POS = {1'b0, {(VAL_W-1){1'b1}}};
  localparam val_t SAT_NEG = -SAT_POS;
  localparam val_t ONE_Q36 = 63'sd68719476736;   // 1.0 in Q.36
  localparam val_t R2_EPS  = 63'sd281474976;     // 1e-6 mm^2 in Q.48

  typedef enum logic {
    KIND_D2U = 1'b0,
    KIND_U2D = 1'b1
  } kind_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PERSP_X  = 3'd0,
    REG_PERSP_Y  = 3'd1,
    REG_CENTER_X = 3'd2,
    REG_CENTER_Y = 3'd3,
    REG_K0       = 3'd4,
    REG_K1       = 3'd5,
    REG_Z_NEG    = 3'd6
  } reg_idx_e;

  typedef struct packed {
    val_t x;
    val_t y;
  } pt_t;

  typedef struct packed {
    logic  valid;
    kind_e kind;
  } tag_t;

  function automatic val_t sat_add(val_t a, val_t b);
    logic signed [VAL_W:0] s;
    s = (VAL_W+1)'(a) + (VAL_W+1)'(b);
    if (s > (VAL_W+1)'(SAT_POS)) begin
      return SAT_POS;
    end else if (s < (VAL_W+1)'(SAT_NEG)) begin
      return SAT_NEG;
    end
    return VAL_W'(s);
  endfunction

  function automatic val_t sat_sub(val_t a, val_t b);
    logic signed [VAL_W:0] s;
    s = (VAL_W+1)'(a) - (VAL_W+1)'(b);
    if (s > (VAL_W+1)'(SAT_POS)) begin
      return SAT_POS;
    end else if (s < (VAL_W+1)'(SAT_NEG)) begin
      return SAT_NEG;
    end
    return VAL_W'(s);
  endfunction

endpackage

### hw/rtl/cfpd_mul.sv
// Pipelined signed multiply with round-half-away shift and magnitude clamp.
// Built from four 31x31 partial products; depends on cfpd_pkg.
module cfpd_mul import cfpd_pkg::*; #(
  parameter int unsigned Shift = 0
) (
  input  logic clk_i,
  input  val_t a_i,
  input  val_t b_i,
  output val_t p_o
);

  localparam int unsigned MagW  = VAL_W - 1;
  localparam int unsigned HalfW = MagW / 2;
  localparam int unsigned ProdW = 2 * MagW;
  localparam logic [ProdW-1:0] Half = (ProdW'(1) << Shift) >> 1;

  logic [MagW-1:0]    abs_a_d, abs_b_d, abs_a_q, abs_b_q;
  logic [MagW-1:0]    pll_d, plh_d, phl_d, phh_d;
  logic [MagW-1:0]    pll_q, plh_q, phl_q, phh_q;
  logic [ProdW-1:0]   prod_d, prod_q, rnd_d, rnd_q;
  logic [MUL_LAT-2:0] neg_q;
  logic [MagW-1:0]    mag;
  val_t               p_d, p_q;

  assign abs_a_d = a_i[VAL_W-1] ? MagW'(-a_i) : MagW'(a_i);
  assign abs_b_d = b_i[VAL_W-1] ? MagW'(-b_i) : MagW'(b_i);

  assign pll_d = abs_a_q[HalfW-1:0]  * abs_b_q[HalfW-1:0];
  assign plh_d = abs_a_q[HalfW-1:0]  * abs_b_q[MagW-1:HalfW];
  assign phl_d = abs_a_q[MagW-1:HalfW] * abs_b_q[HalfW-1:0];
  assign phh_d = abs_a_q[MagW-1:HalfW] * abs_b_q[MagW-1:HalfW];

  assign prod_d = ProdW'(pll_q)
                + ((ProdW'(plh_q) + ProdW'(phl_q)) << HalfW)
                + (ProdW'(phh_q) << MagW);

  assign rnd_d = (prod_q + Half) >> Shift;

  // anything at or above bit 62 exceeds the clamp
  assign mag = (|rnd_q[ProdW-1:MagW]) ? {MagW{1'b1}} : rnd_q[MagW-1:0];
  assign p_d = neg_q[MUL_LAT-2] ? -val_t'({1'b0, mag}) : val_t'({1'b0, mag});

  always_ff @(posedge clk_i) begin
    abs_a_q <= abs_a_d;
    abs_b_q <= abs_b_d;
    neg_q   <= {neg_q[MUL_LAT-3:0], a_i[VAL_W-1] ^ b_i[VAL_W-1]};
    pll_q   <= pll_d;
    plh_q   <= plh_d;
    phl_q   <= phl_d;
    phh_q   <= phh_d;
    prod_q  <= prod_d;
    rnd_q   <= rnd_d;
    p_q     <= p_d;
  end

  assign p_o = p_q;

endmodule

### hw/rtl/cfpd_persp.sv
// Perspective unit: f = 1 +- px*x +- py*y, then scales the point by f.
// Active for items of kind dir_i, else passes the point; uses cfpd_pkg, cfpd_mul.
module cfpd_persp import cfpd_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  kind_e                    dir_i,
  input  logic signed [COEF_W-1:0] px_i,
  input  logic signed [COEF_W-1:0] py_i,
  input  tag_t                     tag_i,
  input  pt_t                      pt_i,
  output tag_t                     tag_o,
  output pt_t                      pt_o
);

  localparam int unsigned FTap      = MUL_LAT + 1;
  localparam int unsigned PassTap   = 2 * MUL_LAT + 1;
  localparam int unsigned LineDepth = 2 * MUL_LAT + 2;

  val_t m_x, m_y, s_x, s_y;
  val_t f1_q, my_q, f_q;
  pt_t  line_q [LineDepth];
  tag_t tag_q  [PERSP_LAT];
  pt_t  pt_q;
  logic sub;
  logic active;

  assign sub    = (dir_i == KIND_U2D);
  assign active = (tag_q[PassTap].kind == dir_i);

  cfpd_mul #(.Shift(PERSP_SH)) u_mul_px (
    .clk_i, .a_i(val_t'(px_i)), .b_i(pt_i.x), .p_o(m_x)
  );
  cfpd_mul #(.Shift(PERSP_SH)) u_mul_py (
    .clk_i, .a_i(val_t'(py_i)), .b_i(pt_i.y), .p_o(m_y)
  );
  cfpd_mul #(.Shift(Q36_SH)) u_mul_sx (
    .clk_i, .a_i(line_q[FTap].x), .b_i(f_q), .p_o(s_x)
  );
  cfpd_mul #(.Shift(Q36_SH)) u_mul_sy (
    .clk_i, .a_i(line_q[FTap].y), .b_i(f_q), .p_o(s_y)
  );

  always_ff @(posedge clk_i) begin
    f1_q <= sub ? sat_sub(ONE_Q36, m_x) : sat_add(ONE_Q36, m_x);
    my_q <= m_y;
    f_q  <= sub ? sat_sub(f1_q, my_q) : sat_add(f1_q, my_q);
    line_q[0] <= pt_i;
    for (int i = 1; i < LineDepth; i++) begin
      line_q[i] <= line_q[i-1];
    end
    pt_q.x <= active ? s_x : line_q[PassTap].x;
    pt_q.y <= active ? s_y : line_q[PassTap].y;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < PERSP_LAT; i++) begin
        tag_q[i] <= '0;
      end
    end else begin
      tag_q[0] <= tag_i;
      for (int i = 1; i < PERSP_LAT; i++) begin
        tag_q[i] <= tag_q[i-1];
      end
    end
  end

  assign tag_o = tag_q[PERSP_LAT-1];
  assign pt_o  = pt_q;

endmodule

### hw/rtl/cfpd_radial.sv
// Radial unit: d = p - c, r^2, k0 + k1*r^2, then p -+ factor*d above the threshold.
// Subtracts for distorted-to-undistorted items; uses cfpd_pkg, cfpd_mul.
module cfpd_radial import cfpd_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic signed [COORD_W-1:0] cx_i,
  input  logic signed [COORD_W-1:0] cy_i,
  input  logic signed [COEF_W-1:0]  k0_i,
  input  logic signed [COEF_W-1:0]  k1_i,
  input  tag_t                      tag_i,
  input  pt_t                       pt_i,
  output tag_t                      tag_o,
  output pt_t                       pt_o
);

  localparam int unsigned DTap   = 2 * MUL_LAT + 2;
  localparam int unsigned BigTap = 2 * MUL_LAT;
  localparam int unsigned PTap   = 3 * MUL_LAT + 2;

  pt_t                 d_q   [DTap+1];
  pt_t                 p_q   [PTap+1];
  tag_t                tag_q [RAD_LAT];
  logic [BigTap:0]     big_q;
  val_t                sq_x, sq_y, m_r, m_x, m_y;
  val_t                r2_q, dr_q;
  val_t                add_x, add_y;
  pt_t                 pt_q;
  logic                sub;

  assign sub   = (tag_q[PTap].kind == KIND_D2U);
  assign add_x = big_q[BigTap] ? m_x : '0;
  assign add_y = big_q[BigTap] ? m_y : '0;

  cfpd_mul #(.Shift(SQ_SH)) u_mul_sqx (
    .clk_i, .a_i(d_q[0].x), .b_i(d_q[0].x), .p_o(sq_x)
  );
  cfpd_mul #(.Shift(SQ_SH)) u_mul_sqy (
    .clk_i, .a_i(d_q[0].y), .b_i(d_q[0].y), .p_o(sq_y)
  );
  cfpd_mul #(.Shift(K1_SH)) u_mul_k1 (
    .clk_i, .a_i(val_t'(k1_i)), .b_i(r2_q), .p_o(m_r)
  );
  cfpd_mul #(.Shift(Q36_SH)) u_mul_dx (
    .clk_i, .a_i(dr_q), .b_i(d_q[DTap].x), .p_o(m_x)
  );
  cfpd_mul #(.Shift(Q36_SH)) u_mul_dy (
    .clk_i, .a_i(dr_q), .b_i(d_q[DTap].y), .p_o(m_y)
  );

  always_ff @(posedge clk_i) begin
    d_q[0].x <= sat_sub(pt_i.x, val_t'(cx_i));
    d_q[0].y <= sat_sub(pt_i.y, val_t'(cy_i));
    for (int i = 1; i <= DTap; i++) begin
      d_q[i] <= d_q[i-1];
    end
    p_q[0] <= pt_i;
    for (int i = 1; i <= PTap; i++) begin
      p_q[i] <= p_q[i-1];
    end
    r2_q  <= sat_add(sq_x, sq_y);
    big_q <= {big_q[BigTap-1:0], (r2_q > R2_EPS)};
    dr_q  <= sat_add(val_t'(k0_i), m_r);
    pt_q.x <= sub ? sat_sub(p_q[PTap].x, add_x) : sat_add(p_q[PTap].x, add_x);
    pt_q.y <= sub ? sat_sub(p_q[PTap].y, add_y) : sat_add(p_q[PTap].y, add_y);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < RAD_LAT; i++) begin
        tag_q[i] <= '0;
      end
    end else begin
      tag_q[0] <= tag_i;
      for (int i = 1; i < RAD_LAT; i++) begin
        tag_q[i] <= tag_q[i-1];
      end
    end
  end

  assign tag_o = tag_q[RAD_LAT-1];
  assign pt_o  = pt_q;

endmodule

### hw/rtl/camera_focal_plane_distortion_map.sv
// Focal-plane radial distortion map, top level. Throughput: one point per cycle;
// busy is never raised, the receiver cannot stall and the pipeline never holds.
// Latency is set by three chained multipliers in the radial unit and two in each
// perspective unit. Reset clears the configuration registers and all valid bits;
// no clearing pass. Depends on cfpd_pkg, cfpd_persp, cfpd_radial, cfpd_mul.
module camera_focal_plane_distortion_map import cfpd_pkg::*; (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // configuration write port
  input  logic                         cfg_we_i,
  input  logic [CFG_IDX_W-1:0]         cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]        cfg_data_i,
  // command side
  input  logic                         start,
  output logic                         busy,
  input  logic                         kind_i,
  input  logic signed [COORD_W-1:0]    x_in_i,
  input  logic signed [COORD_W-1:0]    y_in_i,
  // result side
  output logic                         done_o,
  output logic signed [COORD_W-1:0]    x_out_o,
  output logic signed [COORD_W-1:0]    y_out_o
);

  localparam int unsigned TOTAL_LAT = 2 * PERSP_LAT + RAD_LAT + 2;
  localparam val_t OUT_MAX = 63'sd2147483647;
  localparam val_t OUT_MIN = -63'sd2147483648;

  function automatic logic signed [COORD_W-1:0] sat32(val_t v);
    if (v > OUT_MAX) begin
      return OUT_MAX[COORD_W-1:0];
    end else if (v < OUT_MIN) begin
      return OUT_MIN[COORD_W-1:0];
    end
    return v[COORD_W-1:0];
  endfunction

  // ---------------------------------------------------------------------------
  // Configuration registers. The user must write them only while no point is
  // in flight, unchecked by the block; units read them directly, unstaged.
  // ---------------------------------------------------------------------------
  logic signed [COEF_W-1:0]  persp_x_q, persp_y_q, k0_q, k1_q;
  logic signed [COORD_W-1:0] center_x_q, center_y_q;
  logic                      z_neg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      persp_x_q  <= '0;
      persp_y_q  <= '0;
      center_x_q <= '0;
      center_y_q <= '0;
      k0_q       <= '0;
      k1_q       <= '0;
      z_neg_q    <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (reg_idx_e'(cfg_idx_i))
        REG_PERSP_X:  persp_x_q  <= cfg_data_i[COEF_W-1:0];
        REG_PERSP_Y:  persp_y_q  <= cfg_data_i[COEF_W-1:0];
        REG_CENTER_X: center_x_q <= cfg_data_i[COORD_W-1:0];
        REG_CENTER_Y: center_y_q <= cfg_data_i[COORD_W-1:0];
        REG_K0:       k0_q       <= cfg_data_i[COEF_W-1:0];
        REG_K1:       k1_q       <= cfg_data_i[COEF_W-1:0];
        REG_Z_NEG:    z_neg_q    <= cfg_data_i[0];
        default: ;    // unmapped index: write dropped
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Input stage: accept every cycle, widen to the clamped intermediate format
  // and apply the z sign for undistorted-to-distorted points.
  // ---------------------------------------------------------------------------
  logic accept;
  logic flip;
  val_t x_ext, y_ext;
  tag_t in_tag_q;
  pt_t  in_pt_q;

  assign busy   = 1'b0;
  assign accept = start && !busy;
  assign flip   = (kind_e'(kind_i) == KIND_U2D) && z_neg_q;
  assign x_ext  = val_t'(x_in_i);
  assign y_ext  = val_t'(y_in_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_tag_q <= '0;
    end else begin
      in_tag_q.valid <= accept;
      in_tag_q.kind  <= kind_e'(kind_i);
    end
  end

  always_ff @(posedge clk_i) begin
    in_pt_q.x <= flip ? -x_ext : x_ext;
    in_pt_q.y <= flip ? -y_ext : y_ext;
  end

  // ---------------------------------------------------------------------------
  // Datapath: perspective (distorted side) -> radial -> perspective
  // (undistorted side). Each point is worked on by the units of its kind and
  // passed unchanged through the other perspective unit.
  // ---------------------------------------------------------------------------
  tag_t pa_tag, rad_tag, pb_tag;
  pt_t  pa_pt, rad_pt, pb_pt;

  cfpd_persp u_persp_d2u (
    .clk_i,
    .rst_ni,
    .dir_i (KIND_D2U),
    .px_i  (persp_x_q),
    .py_i  (persp_y_q),
    .tag_i (in_tag_q),
    .pt_i  (in_pt_q),
    .tag_o (pa_tag),
    .pt_o  (pa_pt)
  );

  cfpd_radial u_radial (
    .clk_i,
    .rst_ni,
    .cx_i  (center_x_q),
    .cy_i  (center_y_q),
    .k0_i  (k0_q),
    .k1_i  (k1_q),
    .tag_i (pa_tag),
    .pt_i  (pa_pt),
    .tag_o (rad_tag),
    .pt_o  (rad_pt)
  );

  cfpd_persp u_persp_u2d (
    .clk_i,
    .rst_ni,
    .dir_i (KIND_U2D),
    .px_i  (persp_x_q),
    .py_i  (persp_y_q),
    .tag_i (rad_tag),
    .pt_i  (rad_pt),
    .tag_o (pb_tag),
    .pt_o  (pb_pt)
  );

  // ---------------------------------------------------------------------------
  // Output stage: clamp to 32 bits, one-cycle done strobe per transfer.
  // ---------------------------------------------------------------------------
  logic                      done_q;
  logic signed [COORD_W-1:0] x_out_q, y_out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= pb_tag.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    x_out_q <= sat32(pb_pt.x);
    y_out_q <= sat32(pb_pt.y);
  end

  assign done_o  = done_q;
  assign x_out_o = x_out_q;
  assign y_out_o = y_out_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------

  // every result traces back to a start transfer a fixed latency earlier
  a_done_has_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(accept, TOTAL_LAT))
    else $error("result without matching start transfer");

  // the kind tag stays aligned with its point through all three units
  a_kind_aligned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pb_tag.valid |-> (pb_tag.kind == $past(in_tag_q.kind, 2 * PERSP_LAT + RAD_LAT)))
    else $error("kind tag misaligned at datapath output");

  // distorted-to-undistorted points leave the last unit untouched
  a_u2d_bypass: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pb_tag.valid && pb_tag.kind == KIND_D2U) |-> (pb_pt == $past(rad_pt, PERSP_LAT)))
    else $error("bypass of undistorted-side perspective unit altered the point");

endmodule
